### design/lzss_ring_decompressor_top_assert.svh
// Assertion macros for the LZSS ring decompressor.
// Included by the top level; no other dependencies.
`ifndef LZSS_RING_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define LZRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition never holds outside reset.
`define LZRD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LZRD_ASSERT(lbl, clk, rstn, prop, msg)
`define LZRD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### design/lzrd_pkg.sv
// Shared constants for the LZSS ring decompressor.
// No dependencies; used by the channel interfaces and the top level.
package lzrd_pkg;

  localparam int RING_DEPTH     = 2048;
  localparam int RING_AW        = $clog2(RING_DEPTH);
  localparam int COUNT_BITS_DEF = 24;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 24;
  localparam int POS_W   = 11;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;

  // Token word layout: position in the upper bits, length code below.
  localparam int POS_SHIFT = 5;
  localparam int LEN_W     = 6;

  localparam logic [CMD_W-1:0] CMD_FLAG    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SRC     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 1'd1;

  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 24'hFF_FFFF;
  localparam logic [POS_W-1:0]   START_POS_RST = 11'd2014;

  localparam logic [BYTE_W-1:0] FLAG_TOP = 8'h80;
  localparam logic [LEN_W-1:0]  LEN_BIAS = 6'd3;

endpackage

### design/lzrd_in_if.sv
// Input channel of the LZSS ring decompressor: command and data byte.
// Depends on lzrd_pkg for field widths.
interface lzrd_in_if;
  logic                         valid;
  logic                         ready;
  logic [lzrd_pkg::CMD_W-1:0]   command;
  logic [lzrd_pkg::BYTE_W-1:0]  data_byte;

  modport source(output valid, command, data_byte, input ready);
  modport sink(input valid, command, data_byte, output ready);
endinterface

### design/lzrd_out_if.sv
// Result channel of the LZSS ring decompressor: byte, last and status.
// Depends on lzrd_pkg for field widths.
interface lzrd_out_if;
  logic                         valid;
  logic                         ready;
  logic [lzrd_pkg::BYTE_W-1:0]  out_byte;
  logic                         last;
  logic                         status;

  modport source(output valid, out_byte, last, status, input ready);
  modport sink(input valid, out_byte, last, status, output ready);
endinterface

### design/lzss_ring_decompressor_top.sv
// LZSS decoder with a 2048-byte ring dictionary held in one synchronous RAM (one write
// port, one registered read port). Flag, literal and restart beats are each handled as they
// are accepted, and the first byte of a back-reference word is held until the second one;
// a back-reference copy then moves each output byte by a ring read, then a write-back and
// output load, and the write-back waits while the result side stalls. A restart needs no
// clearing pass, since a fill count kept from the restart write position makes every ring
// entry not yet written since then read as zero. Results leave through one output
// register; an input beat is taken only while that register is empty or its beat leaves
// in the same cycle, so a waiting result holds the input.
// Depends on lzrd_pkg, lzrd_in_if, lzrd_out_if and lzss_ring_decompressor_top_assert.svh.
`include "lzss_ring_decompressor_top_assert.svh"

module lzss_ring_decompressor_top #(
  parameter int COUNT_BITS = lzrd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lzrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lzrd_pkg::CFG_W-1:0]      cfg_wdata,
  lzrd_in_if.sink                         in_ch,
  lzrd_out_if.source                      out_ch
);

  localparam int AW     = lzrd_pkg::RING_AW;
  localparam int FILL_W = AW + 1;
  localparam int BW     = lzrd_pkg::BYTE_W;
  localparam int LW     = lzrd_pkg::LEN_W;
  localparam int CMP_W  = (COUNT_BITS > lzrd_pkg::LIMIT_W) ? COUNT_BITS : lzrd_pkg::LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_WR   = 3'b100
  } state_t;

  // Configuration registers
  logic [lzrd_pkg::LIMIT_W-1:0] out_limit_r;
  logic [lzrd_pkg::POS_W-1:0]   start_pos_r;

  // Decoder state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BW-1:0]     flag_bits_r, flag_bits_nxt;
  logic [BW-1:0]     flag_mask_r, flag_mask_nxt;
  logic              pend_r, pend_nxt;
  logic [BW-1:0]     held_r, held_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [LW-1:0]     rem_r, rem_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_status_r, out_status_nxt;

  // Ring memory
  logic [BW-1:0] ring_mem [lzrd_pkg::RING_DEPTH];
  logic [BW-1:0] rd_data_r;
  logic          rd_ok_r;
  logic          ring_we;
  logic          ring_re;
  logic [BW-1:0] ring_wdata;
  logic          src_ok;

  logic              in_fire;
  logic              slot_free;
  logic              out_load;
  logic [CMP_W-1:0]  eff_limit;
  logic [CMP_W-1:0]  count_ext;
  logic [CMP_W-1:0]  count_inc;
  logic              at_limit;
  logic              want_flag;
  logic              kind_ok;
  logic              token_set;
  logic [2*BW-1:0]   word;
  logic [BW-1:0]     copy_byte;
  logic              copy_done;

  always_comb begin
    if (CMP_W'(out_limit_r) > CMP_W'({COUNT_BITS{1'b1}})) begin
      eff_limit = CMP_W'({COUNT_BITS{1'b1}});
    end else begin
      eff_limit = CMP_W'(out_limit_r);
    end
  end

  assign count_ext = CMP_W'(count_r);
  assign count_inc = count_ext + CMP_W'(1);
  assign at_limit  = (count_ext >= eff_limit);
  assign want_flag = (flag_mask_r == '0);
  assign kind_ok   = ((in_ch.command == lzrd_pkg::CMD_FLAG) && want_flag) ||
                     ((in_ch.command == lzrd_pkg::CMD_SRC) && !want_flag);
  assign token_set = ((flag_bits_r & flag_mask_r) != '0);
  assign word      = {in_ch.data_byte, held_r};

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_ch.valid && in_ch.ready;

  // Entry is live only if written since the last restart; else it reads as zero.
  assign src_ok    = (FILL_W'(AW'(src_r - base_r)) < fill_r);
  assign copy_byte = rd_ok_r ? rd_data_r : '0;
  assign copy_done = (rem_r == LW'(1)) || (count_inc >= eff_limit);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    base_nxt       = base_r;
    fill_nxt       = fill_r;
    flag_bits_nxt  = flag_bits_r;
    flag_mask_nxt  = flag_mask_r;
    pend_nxt       = pend_r;
    held_nxt       = held_r;
    count_nxt      = count_r;
    src_nxt        = src_r;
    rem_nxt        = rem_r;
    out_load       = 1'b0;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    ring_we        = 1'b0;
    ring_re        = 1'b0;
    ring_wdata     = in_ch.data_byte;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == lzrd_pkg::CMD_RESTART) begin
            wp_nxt        = start_pos_r;
            base_nxt      = start_pos_r;
            fill_nxt      = '0;
            flag_bits_nxt = '0;
            flag_mask_nxt = '0;
            pend_nxt      = 1'b0;
            held_nxt      = '0;
            count_nxt     = '0;
          end else if (at_limit) begin
            // drop: stream finished
          end else if (!kind_ok) begin
            out_load       = 1'b1;
            out_byte_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = 1'b1;
          end else if (in_ch.command == lzrd_pkg::CMD_FLAG) begin
            flag_bits_nxt = in_ch.data_byte;
            flag_mask_nxt = lzrd_pkg::FLAG_TOP;
          end else if (!token_set) begin
            ring_we        = 1'b1;
            wp_nxt         = wp_r + 1'b1;
            if (fill_r != FILL_W'(lzrd_pkg::RING_DEPTH)) begin
              fill_nxt = fill_r + 1'b1;
            end
            count_nxt      = count_r + 1'b1;
            out_load       = 1'b1;
            out_byte_nxt   = in_ch.data_byte;
            out_last_nxt   = 1'b1;
            out_status_nxt = 1'b0;
            flag_mask_nxt  = flag_mask_r >> 1;
          end else if (!pend_r) begin
            held_nxt = in_ch.data_byte;
            pend_nxt = 1'b1;
          end else begin
            src_nxt       = word[lzrd_pkg::POS_SHIFT +: AW];
            rem_nxt       = LW'(word[lzrd_pkg::POS_SHIFT-1:0]) + lzrd_pkg::LEN_BIAS;
            pend_nxt      = 1'b0;
            held_nxt      = '0;
            flag_mask_nxt = flag_mask_r >> 1;
            state_nxt     = ST_RD;
          end
        end
      end
      ST_RD: begin
        ring_re   = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        // Hold the read byte until the output register can take it.
        if (slot_free) begin
          ring_we        = 1'b1;
          ring_wdata     = copy_byte;
          wp_nxt         = wp_r + 1'b1;
          if (fill_r != FILL_W'(lzrd_pkg::RING_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
          count_nxt      = count_r + 1'b1;
          out_load       = 1'b1;
          out_byte_nxt   = copy_byte;
          out_last_nxt   = copy_done;
          out_status_nxt = 1'b0;
          src_nxt        = src_r + 1'b1;
          rem_nxt        = rem_r - 1'b1;
          state_nxt      = copy_done ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r  <= lzrd_pkg::OUT_LIMIT_RST;
      start_pos_r  <= lzrd_pkg::START_POS_RST;
      state_r      <= ST_IDLE;
      wp_r         <= lzrd_pkg::START_POS_RST;
      base_r       <= lzrd_pkg::START_POS_RST;
      fill_r       <= '0;
      flag_bits_r  <= '0;
      flag_mask_r  <= '0;
      pend_r       <= 1'b0;
      held_r       <= '0;
      count_r      <= '0;
      src_r        <= '0;
      rem_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lzrd_pkg::CFG_OUT_LIMIT: out_limit_r <= cfg_wdata[lzrd_pkg::LIMIT_W-1:0];
          lzrd_pkg::CFG_START_POS: start_pos_r <= cfg_wdata[lzrd_pkg::POS_W-1:0];
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      base_r      <= base_nxt;
      fill_r      <= fill_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_mask_r <= flag_mask_nxt;
      pend_r      <= pend_nxt;
      held_r      <= held_nxt;
      count_r     <= count_nxt;
      src_r       <= src_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  // Ring RAM: write at the write position, registered read at the copy source.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= ring_wdata;
    end
    if (ring_re) begin
      rd_data_r <= ring_mem[src_r];
      rd_ok_r   <= src_ok;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.status   = out_status_r;

  `LZRD_ASSERT(a_ring_wr_beat, clk, rst_n, ring_we |-> out_load, "ring write without result beat")
  `LZRD_ASSERT(a_rd_then_wr, clk, rst_n, (state_r == ST_RD) |=> (state_r == ST_WR), "copy read not followed by write-back")
  `LZRD_ASSERT(a_copy_rem, clk, rst_n, (state_r != ST_IDLE) |-> (rem_r != '0), "copy active with nothing left")
  `LZRD_ASSERT_NEVER(a_fill_max, clk, rst_n, fill_r > FILL_W'(lzrd_pkg::RING_DEPTH), "fill count past ring depth")

endmodule
